/* design/message_framer_ring_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the message framer
// Concurrent checks that are sampled on clock and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FRAMER_RING_BUFFER_ASSERT_SVH
`define MESSAGE_FRAMER_RING_BUFFER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define MFRB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MFRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MFRB_ASSERT_NOW(lbl, ante, cons, msg)
`define MFRB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/mfrb_pkg.sv */
// ----------------------------------------------------------------------------
// mfrb_pkg
// Constants, codes, types and helpers for the message framer ring buffer.
// ----------------------------------------------------------------------------
package mfrb_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   // Header of one message: type, id, chunk, length low, length high
   localparam int HDR_BYTES  = 5;
   localparam int HDR_CNT_W  = $clog2(HDR_BYTES);
   localparam int HDR_TAIL_W = (HDR_BYTES - 1) * 8;

   // Field widths
   localparam int LEN_W      = 16;
   localparam int LEN_SUM_W  = LEN_W + 1;
   localparam int FREE_OUT_W = 10;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_BEGIN   = 2'd0,
      REQ_PAYLOAD = 2'd1,
      REQ_POP     = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_DROPPED = 3'd1,
      ST_DISCARD = 3'd2,
      ST_STRAY   = 3'd3,
      ST_OWED    = 3'd4
   } status_type;

   // Result fields held between acceptance and the output register
   typedef struct packed {
      status_type             status;
      logic                   tx_valid;
      logic [FREE_OUT_W-1:0]  free_bytes;
      logic [LEN_W-1:0]       bytes_owed;
   } result_type;

   // Advance a ring position by one
   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Advance a ring position past a whole header
   function automatic logic [PTR_W-1:0] skip_header(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + (PTR_W + 1)'(HDR_BYTES);
      if (sum >= (PTR_W + 1)'(RING_DEPTH)) begin
         sum = sum - (PTR_W + 1)'(RING_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

/* design/message_framer_ring_buffer.sv */
// ----------------------------------------------------------------------------
// message_framer_ring_buffer
// Frames length-prefixed messages into a byte ring and drains it to a link.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake               | Contents
//  req_    | in  | req_tvalid/req_tready   | tuser: kind; tdata: header fields, byte
//  rsp_    | out | rsp_tvalid/rsp_tready   | tuser: status, tx flag; tdata: byte, counts
//
//  An admitted begin writes its five header bytes in turn through the single
//  write port of the ring and holds the input side until the last is written.
//  A pop reads the ring into a register; the result leaves through an output
//  register, so a new word is taken while a result waits.
//  Synchronous reset empties the ring at once (pointers and counts only).
//  A stalled result side holds the input side once two words wait, one in
//  the read-latency stage and one in the output register.
// ----------------------------------------------------------------------------
module message_framer_ring_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [47:0] req_tdata,   // msg_type, msg_id, chunk_index,
                                    // payload_length, payload_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [3:0]  rsp_tuser,   // [2:0] status, [3] tx_valid
   output logic [39:0] rsp_tdata    // tx_byte, free_bytes, bytes_owed, zero pad
);

   `include "message_framer_ring_buffer_assert.svh"

   localparam int PW = mfrb_pkg::PTR_W;
   localparam int LW = mfrb_pkg::LEN_W;

   // Input word unpacked
   mfrb_pkg::req_kind_type req_kind;
   logic [7:0]    msg_type;
   logic [7:0]    msg_id;
   logic [7:0]    chunk_index;
   logic [LW-1:0] payload_length;
   logic [7:0]    payload_byte;

   assign req_kind       = mfrb_pkg::req_kind_type'(req_tuser);
   assign msg_type       = req_tdata[7:0];
   assign msg_id         = req_tdata[15:8];
   assign chunk_index    = req_tdata[23:16];
   assign payload_length = req_tdata[39:24];
   assign payload_byte   = req_tdata[47:40];

   // Ring memory
   logic [7:0] ring_mem [mfrb_pkg::RING_DEPTH];
   logic [7:0] rd_data_ff;
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;

   // Control state
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] used_ff, used_in;
   logic [LW-1:0] left_ff, left_in;
   logic          drop_ff, drop_in;

   // Header burst
   logic [mfrb_pkg::HDR_CNT_W-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [PW-1:0]                   hdr_addr_ff, hdr_addr_in;
   logic [mfrb_pkg::HDR_TAIL_W-1:0] hdr_data_ff, hdr_data_in;

   // Result stages
   logic                 a_valid_ff;
   mfrb_pkg::result_type a_ff, a_in;
   logic                 rsp_valid_ff;
   mfrb_pkg::result_type rsp_ff;
   logic [7:0]           rsp_byte_ff;

   logic          req_fire;
   logic          a_move;
   logic          hdr_busy;
   logic [PW-1:0] free_now;
   logic [PW-1:0] free_after;

   assign hdr_busy   = (hdr_cnt_ff != '0);
   assign a_move     = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hdr_busy && (!a_valid_ff || a_move);
   assign req_fire   = req_tvalid && req_tready;
   assign free_now   = PW'(mfrb_pkg::RING_DEPTH - 1) - used_ff;
   assign free_after = PW'(mfrb_pkg::RING_DEPTH - 1) - used_in;

   // Next state of the framer
   always_comb begin
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      used_in     = used_ff;
      left_in     = left_ff;
      drop_in     = drop_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      hdr_addr_in = hdr_addr_ff;
      hdr_data_in = hdr_data_ff;
      mem_we      = 1'b0;
      mem_waddr   = hdr_addr_ff;
      mem_wdata   = hdr_data_ff[7:0];
      mem_re      = 1'b0;
      a_in.status   = mfrb_pkg::ST_DONE;
      a_in.tx_valid = 1'b0;

      // remaining header bytes, one a cycle
      if (hdr_busy) begin
         mem_we      = 1'b1;
         hdr_addr_in = mfrb_pkg::next_pos(hdr_addr_ff);
         hdr_data_in = hdr_data_ff >> 8;
         hdr_cnt_in  = hdr_cnt_ff - mfrb_pkg::HDR_CNT_W'(1);
      end

      if (req_fire) begin
         unique case (req_kind)
            mfrb_pkg::REQ_BEGIN: begin
               if (left_ff != '0) begin
                  a_in.status = mfrb_pkg::ST_OWED;
               end else if ({1'b0, payload_length} + mfrb_pkg::LEN_SUM_W'(mfrb_pkg::HDR_BYTES)
                            > mfrb_pkg::LEN_SUM_W'(free_now)) begin
                  a_in.status = mfrb_pkg::ST_DROPPED;
                  left_in     = payload_length;
                  drop_in     = (payload_length != '0);
               end else begin
                  mem_we      = 1'b1;
                  mem_waddr   = wp_ff;
                  mem_wdata   = msg_type;
                  hdr_addr_in = mfrb_pkg::next_pos(wp_ff);
                  hdr_data_in = {payload_length, chunk_index, msg_id};
                  hdr_cnt_in  = mfrb_pkg::HDR_CNT_W'(mfrb_pkg::HDR_BYTES - 1);
                  wp_in       = mfrb_pkg::skip_header(wp_ff);
                  used_in     = used_ff + PW'(mfrb_pkg::HDR_BYTES);
                  left_in     = payload_length;
                  drop_in     = 1'b0;
               end
            end
            mfrb_pkg::REQ_PAYLOAD: begin
               if (left_ff == '0) begin
                  a_in.status = mfrb_pkg::ST_STRAY;
               end else begin
                  if (drop_ff || free_now == '0) begin
                     a_in.status = mfrb_pkg::ST_DISCARD;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = wp_ff;
                     mem_wdata = payload_byte;
                     wp_in     = mfrb_pkg::next_pos(wp_ff);
                     used_in   = used_ff + PW'(1);
                  end
                  left_in = left_ff - LW'(1);
                  if (left_ff == LW'(1)) begin
                     drop_in = 1'b0;
                  end
               end
            end
            mfrb_pkg::REQ_POP: begin
               if (used_ff != '0) begin
                  a_in.tx_valid = 1'b1;
                  mem_re        = 1'b1;
                  rp_in         = mfrb_pkg::next_pos(rp_ff);
                  used_in       = used_ff - PW'(1);
               end
            end
            mfrb_pkg::REQ_CLEAR: begin
               rp_in   = '0;
               wp_in   = '0;
               used_in = '0;
               left_in = '0;
               drop_in = 1'b0;
            end
            default: begin
               a_in.status = mfrb_pkg::ST_DONE;
            end
         endcase
      end

      a_in.free_bytes = mfrb_pkg::FREE_OUT_W'(free_after);
      a_in.bytes_owed = left_in;
   end

   // Ring write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[rp_ff];
      end
   end

   // Pointers, counts and header burst
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff      <= '0;
         wp_ff      <= '0;
         used_ff    <= '0;
         left_ff    <= '0;
         drop_ff    <= 1'b0;
         hdr_cnt_ff <= '0;
      end else begin
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         used_ff    <= used_in;
         left_ff    <= left_in;
         drop_ff    <= drop_in;
         hdr_cnt_ff <= hdr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_addr_ff <= hdr_addr_in;
      hdr_data_ff <= hdr_data_in;
   end

   // Result stages: read-latency stage, then output register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (a_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_ff <= a_in;
      end
      if (a_move) begin
         rsp_ff      <= a_ff;
         rsp_byte_ff <= a_ff.tx_valid ? rd_data_ff : 8'h00;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.tx_valid, rsp_ff.status};
   assign rsp_tdata  = {6'b0, rsp_ff.bytes_owed, rsp_ff.free_bytes, rsp_byte_ff};

   // Checks
   `MFRB_ASSERT_NOW(a_hdr_blocks, hdr_busy, !req_tready, "word taken during header burst")
   `MFRB_ASSERT_NOW(a_empty_ptrs, 1'b1,
      ((used_ff == '0) == (rp_ff == wp_ff)), "count and pointers disagree")
   `MFRB_ASSERT_NOW(a_drop_owed, drop_ff, (left_ff != '0), "dropping with nothing owed")
   `MFRB_ASSERT_NEXT(a_fire_stage, req_fire, a_valid_ff, "accepted word lost before output")
   `MFRB_ASSERT_NEXT(a_hdr_len,
      (req_fire && req_kind == mfrb_pkg::REQ_BEGIN && hdr_cnt_in != '0),
      (hdr_cnt_ff == mfrb_pkg::HDR_CNT_W'(mfrb_pkg::HDR_BYTES - 1)),
      "header burst of wrong length")

endmodule

/* tb/message_framer_ring_buffer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_framer_ring_buffer_test
// Self-checking bench for the length-prefixed message framer. Request words
// go in through the req_ stream and every result word is checked, field by
// field, against a local model of the ring, the pointers and the owed count.
// Directed corner cases come first. A full-ring fill with a long receiver
// hold-off follows, then random message traffic under several idling mixes.
// ----------------------------------------------------------------------------
module message_framer_ring_buffer_test;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;
   localparam int FILL_BEGINS     = (mfrb_pkg::RING_DEPTH - 1) / mfrb_pkg::HDR_BYTES - 1;
   localparam int FILL_LENGTH     = mfrb_pkg::RING_DEPTH - 1
                                    - mfrb_pkg::HDR_BYTES * (FILL_BEGINS + 1);
   localparam int FILL_DRAIN_POPS = 64;
   localparam int RANDOM_WORDS    = 175;

   // One expected result word
   typedef struct {
      mfrb_pkg::status_type                 status;
      logic                                 tx_valid;
      logic [7:0]                           tx_byte;
      logic [mfrb_pkg::FREE_OUT_W-1:0]      free_bytes;
      logic [mfrb_pkg::LEN_W-1:0]           bytes_owed;
   } framer_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // [1:0] req_type
   logic [47:0] req_tdata;    // msg_type, msg_id, chunk_index, payload_length,
                              // payload_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [3:0]  rsp_tuser;    // [2:0] status, [3] tx_valid
   logic [39:0] rsp_tdata;    // tx_byte, free_bytes, bytes_owed, zero pad

   // Local copy of the framer state
   logic [7:0]                   ring_copy [mfrb_pkg::RING_DEPTH];
   logic [mfrb_pkg::PTR_W-1:0]   rd_pos;
   logic [mfrb_pkg::PTR_W-1:0]   wr_pos;
   logic [mfrb_pkg::LEN_W-1:0]   owed_left;
   logic                         discarding;

   framer_word_type   expected_words [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_asks;
   int quiet_cycles;
   int error_count;
   int words_sent;
   int results_checked;
   int bytes_drained;
   int status_seen [5];

   message_framer_ring_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Free space left in the local ring copy
   function automatic int ring_room();
      logic [mfrb_pkg::PTR_W-1:0] used;
      used = wr_pos - rd_pos;
      return mfrb_pkg::RING_DEPTH - 1 - int'(used);
   endfunction

   function automatic void ring_push(input logic [7:0] b);
      ring_copy[wr_pos] = b;
      wr_pos = wr_pos + mfrb_pkg::PTR_W'(1);
   endfunction

   // Works out the result word of one accepted request and updates the state
   function automatic void predict_framer(input mfrb_pkg::req_kind_type kind,
                                          input logic [47:0] data,
                                          output framer_word_type r);
      logic [mfrb_pkg::LEN_W-1:0] len;
      len          = data[39:24];
      r.status     = mfrb_pkg::ST_DONE;
      r.tx_valid   = 1'b0;
      r.tx_byte    = 8'h00;
      case (kind)
         mfrb_pkg::REQ_BEGIN: begin
            if (owed_left != 0) begin
               r.status = mfrb_pkg::ST_OWED;
            end else if (mfrb_pkg::HDR_BYTES + int'(len) > ring_room()) begin
               r.status   = mfrb_pkg::ST_DROPPED;
               owed_left  = len;
               discarding = (len != 0);
            end else begin
               ring_push(data[7:0]);
               ring_push(data[15:8]);
               ring_push(data[23:16]);
               ring_push(len[7:0]);
               ring_push(len[15:8]);
               owed_left  = len;
               discarding = 1'b0;
            end
         end
         mfrb_pkg::REQ_PAYLOAD: begin
            if (owed_left == 0) begin
               r.status = mfrb_pkg::ST_STRAY;
            end else begin
               if (discarding || ring_room() == 0) r.status = mfrb_pkg::ST_DISCARD;
               else ring_push(data[47:40]);
               owed_left = owed_left - mfrb_pkg::LEN_W'(1);
               if (owed_left == 0) discarding = 1'b0;
            end
         end
         mfrb_pkg::REQ_POP: begin
            if (rd_pos != wr_pos) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = ring_copy[rd_pos];
               rd_pos     = rd_pos + mfrb_pkg::PTR_W'(1);
            end
         end
         default: begin
            rd_pos     = '0;
            wr_pos     = '0;
            owed_left  = '0;
            discarding = 1'b0;
         end
      endcase
      r.free_bytes = mfrb_pkg::FREE_OUT_W'(ring_room());
      r.bytes_owed = owed_left;
   endfunction

   function automatic logic [47:0] pack_fields(input logic [7:0] mtype, mid, chunk,
                                               input logic [15:0] len,
                                               input logic [7:0] pbyte);
      return {pbyte, len, chunk, mid, mtype};
   endfunction

   function automatic logic [47:0] random_fields();
      return 48'({$urandom, $urandom});
   endfunction

   // Offers one request word, waits for it to be taken, then maybe idles
   task automatic send_word(input mfrb_pkg::req_kind_type kind, input logic [47:0] data);
      framer_word_type want;
      req_tuser  <= kind;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_framer(kind, data, want);
      expected_words.push_back(want);
      words_sent++;
      // each idle cycle is drawn afresh, so the idle share matches the percentage
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int asks_seen;
      hold_left  = 0;
      asks_seen  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asks != asks_seen) begin
            asks_seen = hold_off_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      framer_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("result word with no expectation waiting: tuser %h tdata %h",
                   rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            results_checked++;
            status_seen[int'(want.status)]++;
            if (want.tx_valid) bytes_drained++;
            if (rsp_tuser[2:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:0]);
               error_count++;
            end
            if (rsp_tuser[3] !== want.tx_valid) begin
               $error("tx_valid: expected %0d, got %0d", want.tx_valid, rsp_tuser[3]);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[17:8] !== want.free_bytes) begin
               $error("free_bytes: expected %0d, got %0d", want.free_bytes,
                      rsp_tdata[17:8]);
               error_count++;
            end
            if (rsp_tdata[33:18] !== want.bytes_owed) begin
               $error("bytes_owed: expected %0d, got %0d", want.bytes_owed,
                      rsp_tdata[33:18]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("message_framer_ring_buffer_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Corner cases: empty pop, stray, owed begin, clear mid-message, drop
   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_word(mfrb_pkg::REQ_POP, random_fields());
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'hFF, 8'h00, 8'hA5, 16'd3, 8'h00));
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'h11, 8'h22, 8'h33, 16'd4, 8'h44));
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'h00, 8'h00, 8'h00, 16'd0, 8'hFF));
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h00));
      // clear with one byte still owed, then that byte counts as stray
      send_word(mfrb_pkg::REQ_CLEAR, random_fields());
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'h00, 8'h00, 8'h00, 16'd0, 8'h7E));
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'h00, 8'hFF, 8'h5A, 16'd0, 8'hFF));
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'h80, 8'h01, 8'hFE, 16'd2, 8'h00));
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'h00, 8'h00, 8'h00, 16'd0, 8'h00));
      send_word(mfrb_pkg::REQ_PAYLOAD, pack_fields(8'h00, 8'h00, 8'h00, 16'd0, 8'hFF));
      repeat (6) send_word(mfrb_pkg::REQ_POP, random_fields());
      send_word(mfrb_pkg::REQ_CLEAR, random_fields());
      // largest length cannot fit: dropped, later bytes discarded
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'hC3, 8'h3C, 8'h99, 16'hFFFF, 8'h00));
      send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      send_word(mfrb_pkg::REQ_BEGIN, pack_fields(8'h01, 8'h02, 8'h03, 16'd1, 8'h04));
      send_word(mfrb_pkg::REQ_CLEAR, random_fields());
   endtask

   // Fill the ring to the last slot, drops at full, exact fit, part drain, clear
   task automatic test_ring_fill();
      logic [47:0] data;
      sender_idle_pct    = 0;
      receiver_stall_pct = 10;
      send_word(mfrb_pkg::REQ_CLEAR, random_fields());
      // hold the result side off while empty messages keep coming
      hold_off_asks <= hold_off_asks + 1;
      repeat (FILL_BEGINS) begin
         data = random_fields();
         data[39:24] = 16'd0;
         send_word(mfrb_pkg::REQ_BEGIN, data);
      end
      // last message takes exactly the slots that are left
      data = random_fields();
      data[39:24] = 16'(FILL_LENGTH);
      send_word(mfrb_pkg::REQ_BEGIN, data);
      repeat (FILL_LENGTH) send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      data = random_fields();
      data[39:24] = 16'd0;
      send_word(mfrb_pkg::REQ_BEGIN, data);
      send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      data[39:24] = 16'd1;
      send_word(mfrb_pkg::REQ_BEGIN, data);
      send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      repeat (2 * mfrb_pkg::HDR_BYTES) send_word(mfrb_pkg::REQ_POP, random_fields());
      data = random_fields();
      data[39:24] = 16'(mfrb_pkg::HDR_BYTES);
      send_word(mfrb_pkg::REQ_BEGIN, data);
      repeat (mfrb_pkg::HDR_BYTES) send_word(mfrb_pkg::REQ_PAYLOAD, random_fields());
      data[39:24] = 16'd0;
      send_word(mfrb_pkg::REQ_BEGIN, data);
      repeat (FILL_DRAIN_POPS) send_word(mfrb_pkg::REQ_POP, random_fields());
      send_word(mfrb_pkg::REQ_CLEAR, random_fields());
   endtask

   // Random message traffic, mostly well-formed, some noise
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int words);
      logic [47:0] data;
      int pick;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < words; n++) begin
         data = random_fields();
         pick = $urandom_range(99);
         if (owed_left != 0) begin
            // large owed counts come mostly from dropped messages
            if (owed_left > 300 || pick < 2) send_word(mfrb_pkg::REQ_CLEAR, data);
            else if (pick < 5) send_word(mfrb_pkg::REQ_BEGIN, data);
            else if (pick < 20) send_word(mfrb_pkg::REQ_POP, data);
            else send_word(mfrb_pkg::REQ_PAYLOAD, data);
         end else if (pick < 35) begin
            pick = $urandom_range(99);
            if (pick < 60) data[39:24] = 16'($urandom_range(0, 20));
            else if (pick < 90) data[39:24] = 16'($urandom_range(21, 300));
            send_word(mfrb_pkg::REQ_BEGIN, data);
         end else if (pick < 85) begin
            send_word(mfrb_pkg::REQ_POP, data);
         end else if (pick < 93) begin
            send_word(mfrb_pkg::REQ_PAYLOAD, data);
         end else begin
            send_word(mfrb_pkg::REQ_CLEAR, data);
         end
      end
   endtask

   // Main sequence
   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tuser          = mfrb_pkg::REQ_POP;
      req_tdata          = '0;
      rd_pos             = '0;
      wr_pos             = '0;
      owed_left          = '0;
      discarding         = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_asks      = 0;
      error_count        = 0;
      words_sent         = 0;
      results_checked    = 0;
      bytes_drained      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_ring_fill();
      test_random_traffic(0, 0, RANDOM_WORDS);
      test_random_traffic(70, 0, RANDOM_WORDS);
      test_random_traffic(0, 70, RANDOM_WORDS);
      test_random_traffic(35, 35, RANDOM_WORDS);

      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words: corner cases, a full-ring fill under a long hold-off,",
               words_sent);
      $display("random traffic in four idling mixes; %0d results checked, %0d bytes %s",
               results_checked, bytes_drained,
               "drained; done/dropped/discarded/stray/owed:");
      $display("   %0d/%0d/%0d/%0d/%0d", status_seen[0], status_seen[1],
               status_seen[2], status_seen[3], status_seen[4]);
      if (error_count == 0) begin
         $display("message_framer_ring_buffer_test OK");
      end else begin
         $display("message_framer_ring_buffer_test NOT OK");
      end
      $finish;
   end

endmodule
